// File: sv/pbsc_pkg.sv
`default_nettype none
package pbsc_pkg;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int RAILS_W  = 2;
   localparam int COUNT_W  = 8;
   localparam int BEAT_W   = 2;

   localparam int TICKS_PER_SECOND_DEF   = 250;
   localparam int LONG_PRESS_SECONDS_DEF = 4;

   // Operation codes of an input beat.
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_BUTTON = 2'd1;
   localparam logic [OP_W-1:0] OP_BOOT   = 2'd2;

   // Power status codes.
   localparam logic [STATUS_W-1:0] ST_OFF        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ON         = 3'd1;
   localparam logic [STATUS_W-1:0] ST_STR        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STD        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STR_RESUME = 3'd4;
   localparam logic [STATUS_W-1:0] BLOCKED_NONE  = 3'd5;

   // Beat positions within a power-on sequence.
   localparam logic [BEAT_W-1:0] BEAT_RESET_LOW  = 2'd0;
   localparam logic [BEAT_W-1:0] BEAT_RESET_HIGH = 2'd1;
   localparam logic [BEAT_W-1:0] BEAT_FINAL      = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] boot_status;
   } item_type;

   typedef struct packed {
      logic                pulse;
      logic [STATUS_W-1:0] old_status;
      logic [RAILS_W-1:0]  old_rails;
      logic [STATUS_W-1:0] new_status;
      logic [RAILS_W-1:0]  new_rails;
   } seq_desc_type;

   // Rail levels for a status: bit 0 is rail A, bit 1 is rail B.
   function automatic logic [RAILS_W-1:0] rails_for(input logic [STATUS_W-1:0] status);
      logic [RAILS_W-1:0] rails;
      case (status)
         ST_STR:        rails = 2'b01;
         ST_ON:         rails = 2'b11;
         ST_STR_RESUME: rails = 2'b11;
         default:       rails = 2'b00;
      endcase
      return rails;
   endfunction

endpackage
`default_nettype wire

// File: sv/pbsc_if.sv
`default_nettype none
interface pbsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [pbsc_pkg::OP_W-1:0]     op;
   logic [pbsc_pkg::STATUS_W-1:0] boot_status;

   modport source(output valid, op, boot_status, input ready);
   modport sink(input valid, op, boot_status, output ready);
endinterface

interface pbsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pbsc_pkg::STATUS_W-1:0] status;
   logic                          rail_a;
   logic                          rail_b;
   logic                          reset_line;
   logic                          last;

   modport source(output valid, status, rail_a, rail_b, reset_line, last, input ready);
   modport sink(input valid, status, rail_a, rail_b, reset_line, last, output ready);
endinterface
`default_nettype wire

// File: sv/pbsc_in_stage.sv
`default_nettype none
module pbsc_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   pbsc_req_if.sink                req_if,
   input  wire logic               take,
   output pbsc_pkg::item_type      item,
   output logic                    item_valid
);

   logic               valid_ff;
   logic               valid_in;
   pbsc_pkg::item_type item_ff;
   logic               accept;

   assign req_if.ready = !valid_ff || take;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.op          <= req_if.op;
         item_ff.boot_status <= req_if.boot_status;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule
`default_nettype wire

// File: sv/pbsc_core.sv
`default_nettype none
module pbsc_core #(
   parameter int TICKS_PER_SECOND   = pbsc_pkg::TICKS_PER_SECOND_DEF,
   parameter int LONG_PRESS_SECONDS = pbsc_pkg::LONG_PRESS_SECONDS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [pbsc_pkg::STATUS_W-1:0] csr_wdata,
   input  wire pbsc_pkg::item_type            item,
   input  wire logic                          item_valid,
   input  wire logic                          seq_free,
   output logic                               take,
   output logic                               seq_load,
   output pbsc_pkg::seq_desc_type             seq_desc
);

   localparam logic [pbsc_pkg::COUNT_W-1:0] TICKS_C = pbsc_pkg::COUNT_W'(TICKS_PER_SECOND);
   localparam logic [pbsc_pkg::COUNT_W-1:0] HOLD_C  = pbsc_pkg::COUNT_W'(LONG_PRESS_SECONDS);

   logic [pbsc_pkg::STATUS_W-1:0] blocked_ff;
   logic [pbsc_pkg::COUNT_W-1:0]  tick_ff, tick_in;
   logic [pbsc_pkg::COUNT_W-1:0]  held_ff, held_in;
   logic                          down_ff, down_in;
   logic                          lpd_ff, lpd_in;
   logic [pbsc_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [pbsc_pkg::RAILS_W-1:0]  rails_ff, rails_in;

   logic                          want_req;
   logic                          at_boot;
   logic [pbsc_pkg::STATUS_W-1:0] want;
   logic                          go;
   logic [pbsc_pkg::COUNT_W-1:0]  tick_inc;
   logic [pbsc_pkg::COUNT_W-1:0]  held_inc;

   assign tick_inc = tick_ff + 1'b1;
   assign held_inc = held_ff + 1'b1;

   // Decide what the item asks for and the counter and flag updates.
   always_comb begin
      tick_in  = tick_ff;
      held_in  = held_ff;
      down_in  = down_ff;
      lpd_in   = lpd_ff;
      want_req = 1'b0;
      at_boot  = 1'b0;
      want     = pbsc_pkg::ST_OFF;
      case (item.op)
         pbsc_pkg::OP_TICK: begin
            tick_in = tick_inc;
            if (down_ff && tick_inc == TICKS_C) begin
               tick_in = '0;
               held_in = held_inc;
               if (held_inc == HOLD_C && status_ff != pbsc_pkg::ST_OFF) begin
                  lpd_in   = 1'b1;
                  want_req = 1'b1;
                  want     = pbsc_pkg::ST_OFF;
               end
            end
         end
         pbsc_pkg::OP_BUTTON: begin
            if (!down_ff) begin
               tick_in = '0;
               held_in = '0;
               down_in = 1'b1;
            end else begin
               down_in = 1'b0;
               held_in = '0;
               case (status_ff)
                  pbsc_pkg::ST_OFF: begin
                     if (!lpd_ff) begin
                        want_req = 1'b1;
                        want     = pbsc_pkg::ST_ON;
                     end else begin
                        lpd_in = 1'b0;
                     end
                  end
                  pbsc_pkg::ST_STR: begin
                     want_req = 1'b1;
                     want     = pbsc_pkg::ST_STR_RESUME;
                  end
                  pbsc_pkg::ST_STD: begin
                     want_req = 1'b1;
                     want     = pbsc_pkg::ST_ON;
                  end
                  default: begin
                     want_req = 1'b0;
                  end
               endcase
            end
         end
         pbsc_pkg::OP_BOOT: begin
            if (item.boot_status <= pbsc_pkg::ST_STR_RESUME) begin
               want_req = 1'b1;
               at_boot  = 1'b1;
               want     = item.boot_status;
            end
         end
         default: begin
            want_req = 1'b0;
         end
      endcase
   end

   // Outside boot, a request for the present or the blocked status is dropped.
   assign go = want_req && (at_boot || !(want == status_ff || want == blocked_ff));

   assign take     = item_valid && (!go || seq_free);
   assign seq_load = take && go;

   assign status_in = go ? want : status_ff;
   assign rails_in  = go ? pbsc_pkg::rails_for(want) : rails_ff;

   assign seq_desc.pulse      = (want == pbsc_pkg::ST_ON);
   assign seq_desc.old_status = status_ff;
   assign seq_desc.old_rails  = rails_ff;
   assign seq_desc.new_status = want;
   assign seq_desc.new_rails  = pbsc_pkg::rails_for(want);

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= pbsc_pkg::BLOCKED_NONE;
         tick_ff    <= '0;
         held_ff    <= '0;
         down_ff    <= 1'b0;
         lpd_ff     <= 1'b0;
         status_ff  <= pbsc_pkg::ST_OFF;
         rails_ff   <= '0;
      end else begin
         if (csr_we) begin
            blocked_ff <= csr_wdata;
         end
         if (take) begin
            tick_ff   <= tick_in;
            held_ff   <= held_in;
            down_ff   <= down_in;
            lpd_ff    <= lpd_in;
            status_ff <= status_in;
            rails_ff  <= rails_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: sv/pbsc_out_seq.sv
`default_nettype none
module pbsc_out_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  seq_load,
   input  wire pbsc_pkg::seq_desc_type seq_desc,
   output logic                       seq_free,
   pbsc_rsp_if.source                 rsp_if
);

   logic                          valid_ff, valid_in;
   logic [pbsc_pkg::BEAT_W-1:0]   beat_ff, beat_in;
   pbsc_pkg::seq_desc_type        desc_ff;
   logic                          final_beat;
   logic                          fire;
   logic                          use_old;

   assign final_beat = !desc_ff.pulse || (beat_ff == pbsc_pkg::BEAT_FINAL);
   assign fire       = valid_ff && rsp_if.ready;
   assign seq_free   = !valid_ff || (fire && final_beat);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (seq_load) begin
         valid_in = 1'b1;
         beat_in  = pbsc_pkg::BEAT_RESET_LOW;
      end else if (fire) begin
         if (final_beat) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= pbsc_pkg::BEAT_RESET_LOW;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_load) begin
         desc_ff <= seq_desc;
      end
   end

   // The reset pulse beats still show the status and rails from before power-on.
   assign use_old = desc_ff.pulse && (beat_ff != pbsc_pkg::BEAT_FINAL);

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.status     = use_old ? desc_ff.old_status : desc_ff.new_status;
   assign rsp_if.rail_a     = use_old ? desc_ff.old_rails[0] : desc_ff.new_rails[0];
   assign rsp_if.rail_b     = use_old ? desc_ff.old_rails[1] : desc_ff.new_rails[1];
   assign rsp_if.reset_line = !(desc_ff.pulse && beat_ff == pbsc_pkg::BEAT_RESET_LOW);
   assign rsp_if.last       = final_beat;

endmodule
`default_nettype wire

// File: sv/power_button_state_controller_top.sv
// Channel  Direction  Payload                                      Beat taken when
// req_if   in         op, boot_status                              valid && ready
// rsp_if   out        status, rail_a, rail_b, reset_line, last     valid && ready
// csr      in         csr_wdata (blocked status)                   csr_we
//
// An input beat is registered, then decided against the held state; a new beat can
// enter every cycle unless results back up, and results drain at one beat per cycle
// while ready. An item gives zero, one or three result beats; power-on gives three,
// which holds back the input if later items also give results. Synchronous active-high
// reset clears the state to power off with both rails low. A stalled result holds its
// beat; the input stage accepts only when it is empty or its item moves on.
`default_nettype none
module power_button_state_controller_top #(
   parameter int TICKS_PER_SECOND   = pbsc_pkg::TICKS_PER_SECOND_DEF,
   parameter int LONG_PRESS_SECONDS = pbsc_pkg::LONG_PRESS_SECONDS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pbsc_req_if.sink                           req_if,
   pbsc_rsp_if.source                         rsp_if,
   input  wire logic                          csr_we,
   input  wire logic [pbsc_pkg::STATUS_W-1:0] csr_wdata
);

   pbsc_pkg::item_type     item;
   logic                   item_valid;
   logic                   take;
   logic                   seq_free;
   logic                   seq_load;
   pbsc_pkg::seq_desc_type seq_desc;

   pbsc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .take       (take),
      .item       (item),
      .item_valid (item_valid)
   );

   pbsc_core #(
      .TICKS_PER_SECOND   (TICKS_PER_SECOND),
      .LONG_PRESS_SECONDS (LONG_PRESS_SECONDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item       (item),
      .item_valid (item_valid),
      .seq_free   (seq_free),
      .take       (take),
      .seq_load   (seq_load),
      .seq_desc   (seq_desc)
   );

   pbsc_out_seq u_out (
      .clock    (clock),
      .reset    (reset),
      .seq_load (seq_load),
      .seq_desc (seq_desc),
      .seq_free (seq_free),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire

// File: sv/pbsc_checker.sv
`default_nettype none
module pbsc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [pbsc_pkg::STATUS_W-1:0] rsp_status,
   input wire logic                          rsp_rail_a,
   input wire logic                          rsp_rail_b,
   input wire logic                          rsp_reset_line,
   input wire logic                          rsp_last
);

   // A stalled result beat keeps its status, reset line and last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last)
         && $stable(rsp_reset_line))
      else $error("stalled result beat changed");

   // A sequence that is not finished continues in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("result sequence broken off");

   // Reset is asserted only inside a power-on sequence, never on its final beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reset_line |-> !rsp_last)
      else $error("reset asserted on a final beat");

   // Powered on means both rails are up once the sequence has finished.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_status == pbsc_pkg::ST_ON |-> rsp_rail_a && rsp_rail_b)
      else $error("power on without both rails");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind power_button_state_controller_top pbsc_checker u_pbsc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_rail_a     (rsp_if.rail_a),
   .rsp_rail_b     (rsp_if.rail_b),
   .rsp_reset_line (rsp_if.reset_line),
   .rsp_last       (rsp_if.last)
);
`default_nettype wire

// File: test/tb_power_button_state_controller_top.sv
`timescale 1ns / 1ps
module tb_power_button_state_controller_top;
   import pbsc_pkg::*;

   localparam logic [COUNT_W-1:0] TICK_LIMIT  = COUNT_W'(TICKS_PER_SECOND_DEF);
   localparam logic [COUNT_W-1:0] PRESS_LIMIT = COUNT_W'(LONG_PRESS_SECONDS_DEF);

   // The one operation code that the package leaves unnamed.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int MAX_WAIT    = 11;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                rail_a;
      logic                rail_b;
      logic                reset_line;
      logic                last;
   } pin_beat_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [STATUS_W-1:0] csr_wdata;

   pbsc_req_if req_bus();
   pbsc_rsp_if rsp_bus();

   power_button_state_controller_top #(
      .TICKS_PER_SECOND  (TICKS_PER_SECOND_DEF),
      .LONG_PRESS_SECONDS(LONG_PRESS_SECONDS_DEF)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_bus),
      .rsp_if   (rsp_bus),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   item_type     item_queue [$];
   pin_beat_type expected_pins [$];
   int           queued_items;
   int           fail_count;
   logic         no_gaps;
   logic         hold_trigger;
   logic         sink_hold;

   // Predicted state of the controller.
   logic [COUNT_W-1:0]  pwr_ticks;
   logic [COUNT_W-1:0]  pwr_held;
   logic                pwr_button_down;
   logic                pwr_long_press;
   logic [STATUS_W-1:0] pwr_status;
   logic [RAILS_W-1:0]  pwr_rails;
   logic                pwr_reset_level;
   logic [STATUS_W-1:0] pwr_blocked;

   function automatic void push_pins(input logic last);
      expected_pins.push_back('{status: pwr_status, rail_a: pwr_rails[0],
                                rail_b: pwr_rails[1], reset_line: pwr_reset_level,
                                last: last});
   endfunction

   function automatic void request_status(input logic [STATUS_W-1:0] want,
                                          input logic at_boot);
      if (!at_boot && (want == pwr_status || want == pwr_blocked)) return;
      case (want)
         ST_ON: begin
            // Reset is pulsed low and high under the old status first.
            pwr_reset_level = 1'b0;
            push_pins(1'b0);
            pwr_reset_level = 1'b1;
            push_pins(1'b0);
            pwr_rails = 2'b11;
         end
         ST_STR:        pwr_rails = 2'b01;
         ST_STR_RESUME: pwr_rails = 2'b11;
         default:       pwr_rails = 2'b00;
      endcase
      pwr_status = want;
      push_pins(1'b1);
   endfunction

   function automatic void advance_power_state(input logic [OP_W-1:0] code,
                                               input logic [STATUS_W-1:0] stored);
      case (code)
         OP_TICK: begin
            pwr_ticks = pwr_ticks + 1'b1;
            if (pwr_button_down && pwr_ticks == TICK_LIMIT) begin
               pwr_held  = pwr_held + 1'b1;
               pwr_ticks = '0;
               if (pwr_held == PRESS_LIMIT && pwr_status != ST_OFF) begin
                  pwr_long_press = 1'b1;
                  request_status(ST_OFF, 1'b0);
               end
            end
         end
         OP_BUTTON: begin
            if (!pwr_button_down) begin
               pwr_ticks       = '0;
               pwr_held        = '0;
               pwr_button_down = 1'b1;
            end else begin
               pwr_button_down = 1'b0;
               pwr_held        = '0;
               case (pwr_status)
                  ST_OFF: begin
                     if (!pwr_long_press) request_status(ST_ON, 1'b0);
                     else pwr_long_press = 1'b0;
                  end
                  ST_STR:  request_status(ST_STR_RESUME, 1'b0);
                  ST_STD:  request_status(ST_ON, 1'b0);
                  default: ;
               endcase
            end
         end
         OP_BOOT: begin
            if (stored <= ST_STR_RESUME) request_status(stored, 1'b1);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pwr_ticks       = '0;
         pwr_held        = '0;
         pwr_button_down = 1'b0;
         pwr_long_press  = 1'b0;
         pwr_status      = ST_OFF;
         pwr_rails       = 2'b00;
         pwr_reset_level = 1'b1;
         pwr_blocked     = BLOCKED_NONE;
      end else begin
         if (csr_we) pwr_blocked = csr_wdata;
         if (req_bus.valid && req_bus.ready)
            advance_power_state(req_bus.op, req_bus.boot_status);
      end
   end

   // Request driver: one beat offered at a time, with a drawn gap after each.
   item_type offer;
   int       src_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         src_gap = 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (src_gap > 0) begin
            src_gap = src_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (item_queue.size() != 0) begin
            offer = item_queue.pop_front();
            req_bus.op          <= offer.op;
            req_bus.boot_status <= offer.boot_status;
            req_bus.valid       <= 1'b1;
            src_gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   task automatic report_beat(input string what, input pin_beat_type want,
                              input pin_beat_type got);
      if (fail_count < 10)
         $display({"%s: expected status=%0d rail_a=%b rail_b=%b reset=%b last=%b,",
                   " got status=%0d rail_a=%b rail_b=%b reset=%b last=%b"},
                  what, want.status, want.rail_a, want.rail_b, want.reset_line, want.last,
                  got.status, got.rail_a, got.rail_b, got.reset_line, got.last);
      fail_count = fail_count + 1;
   endtask

   // Result monitor with its own drawn stall after each beat.
   pin_beat_type got_pins;
   pin_beat_type want_pins;
   int           sink_stall;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_pins = '{status: rsp_bus.status, rail_a: rsp_bus.rail_a,
                         rail_b: rsp_bus.rail_b, reset_line: rsp_bus.reset_line,
                         last: rsp_bus.last};
            if (expected_pins.size() == 0) begin
               report_beat("unexpected beat", '0, got_pins);
            end else begin
               want_pins = expected_pins.pop_front();
               if (got_pins !== want_pins) report_beat("mismatch", want_pins, got_pins);
            end
            sink_stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
         end
         rsp_bus.ready <= (sink_stall == 0) && !sink_hold;
      end
   end

   // Long hold-off of the result side, counted here once the stimulus asks.
   initial begin
      sink_hold = 1'b0;
      wait (hold_trigger);
      @(posedge clock);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      sink_hold <= 1'b0;
   end

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [STATUS_W-1:0] draw_status(input int unsigned hi,
                                                      input int unsigned lo);
      return STATUS_W'($urandom_range(hi, lo));
   endfunction

   task automatic queue_item(input logic [OP_W-1:0] code, input logic [STATUS_W-1:0] stored);
      item_queue.push_back('{op: code, boot_status: stored});
      queued_items = queued_items + 1;
   endtask

   // Waits at falling edges, when every process of the rising edge has settled.
   task automatic drain(input int settle);
      while (item_queue.size() != 0 || req_bus.valid || expected_pins.size() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_blocked(input logic [STATUS_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly complete press, hold and release sequences, with boots and noise.
   task automatic queue_random(input int count);
      int start;
      int pick;
      int hold;
      start = queued_items;
      while (queued_items - start < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            hold = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
            queue_item(OP_BUTTON, draw_status(7, 0));
            repeat (hold) queue_item(OP_TICK, draw_status(7, 0));
            queue_item(OP_BUTTON, draw_status(7, 0));
         end else if (pick < 7) begin
            if ($urandom_range(0, 5) == 0) queue_item(OP_BOOT, draw_status(7, 5));
            else queue_item(OP_BOOT, draw_status(4, 0));
         end else if (pick == 7) begin
            repeat ($urandom_range(1, 3)) queue_item(OP_TICK, draw_status(7, 0));
         end else if (pick == 8) begin
            queue_item(OP_BUTTON, draw_status(7, 0));
         end else begin
            queue_item(OP_UNUSED, draw_status(7, 0));
         end
      end
   endtask

   logic [STATUS_W-1:0] blocked_plan [0:6];
   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_TICK;
      req_bus.boot_status = '0;
      rsp_bus.ready = 1'b0;
      queued_items  = 0;
      fail_count    = 0;
      no_gaps       = 1'b0;
      hold_trigger  = 1'b0;
      blocked_plan[0] = BLOCKED_NONE;
      blocked_plan[1] = ST_OFF;
      blocked_plan[2] = ST_ON;
      blocked_plan[3] = ST_STR;
      blocked_plan[4] = ST_STD;
      blocked_plan[5] = ST_STR_RESUME;
      blocked_plan[6] = BLOCKED_NONE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_blocked(BLOCKED_NONE);

      // Release from off, str and std; a short press with ticks; boots.
      queue_item(OP_BUTTON, 3'd0);
      queue_item(OP_BUTTON, 3'd7);
      queue_item(OP_BOOT, ST_STR);
      queue_item(OP_BUTTON, 3'd0);
      queue_item(OP_BUTTON, 3'd0);
      queue_item(OP_BOOT, ST_STD);
      queue_item(OP_BUTTON, 3'd7);
      queue_item(OP_BUTTON, 3'd7);
      queue_item(OP_BUTTON, 3'd0);
      repeat (4) queue_item(OP_TICK, 3'd7);
      queue_item(OP_BUTTON, 3'd0);
      // A power-on at boot pulses reset even when already on.
      queue_item(OP_BOOT, ST_ON);
      queue_item(OP_BOOT, ST_ON);
      queue_item(OP_BOOT, 3'd7);
      queue_item(OP_UNUSED, 3'd7);
      queue_item(OP_BOOT, ST_STR_RESUME);
      queue_item(OP_BOOT, ST_OFF);
      // A press with ticks while off; its release powers on.
      queue_item(OP_BUTTON, 3'd7);
      repeat (4) queue_item(OP_TICK, 3'd0);
      queue_item(OP_BUTTON, 3'd7);
      drain(SETTLE);

      for (int i = 0; i < 7; i++) begin
         write_blocked(blocked_plan[i]);
         @(negedge clock);
         no_gaps = (i % 2 == 1);
         queue_random(22);
         // The sender stops here until every result is back.
         drain(0);
         queue_random(22);
         drain(SETTLE);
      end

      // Results pile up behind a held-off receiver and stall the input.
      write_blocked(ST_STR);
      @(negedge clock);
      no_gaps      = 1'b1;
      hold_trigger = 1'b1;
      repeat (40) queue_item(OP_BOOT, draw_status(4, 0));
      drain(SETTLE);
      no_gaps = 1'b0;
      drain(20);

      if (fail_count == 0 && expected_pins.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
